@@ hw/rtl/lbct_pkg.sv @@
package lbct_pkg;

    // Field widths.
    localparam int SEL_W   = 5;
    localparam int LEVEL_W = 8;
    localparam int CH_W    = 8;
    localparam int COLOR_W = 24;
    localparam int STEP_W  = 6;
    localparam int SLOTS   = 8;

    // Color selection.
    localparam int RAINBOW_STEPS = 42;
    localparam logic [SEL_W-1:0] PALETTE_SIZE = 5'd9;
    localparam logic [SEL_W-1:0] SEL_RAINBOW  = 5'd9;

    // Channel scaling by a fixed-point reciprocal of (MAX_LEVEL + 1).
    localparam int SCALE_SHIFT = 24;
    localparam int RECIP_W     = 24;
    localparam int FACTOR_W    = 25;

    // Parameter defaults.
    localparam int MAX_LEVEL_DEF = 255;
    localparam int TRAIL_LEN_DEF = 8;

    typedef logic [COLOR_W-1:0]  color_t;
    typedef logic [STEP_W-1:0]   step_t;
    typedef logic [FACTOR_W-1:0] factor_t;

    typedef struct packed {
        logic signed [SEL_W-1:0] color_select;
        logic [LEVEL_W-1:0]      brightness;
    } tick_t;

    typedef struct packed {
        logic [COLOR_W-1:0] slot0_color;
        logic [COLOR_W-1:0] slot1_color;
        logic [COLOR_W-1:0] slot2_color;
        logic [COLOR_W-1:0] slot3_color;
        logic [COLOR_W-1:0] slot4_color;
        logic [COLOR_W-1:0] slot5_color;
        logic [COLOR_W-1:0] slot6_color;
        logic [COLOR_W-1:0] slot7_color;
    } frame_t;

    // Fixed palette colors.
    function automatic color_t palette_color(input logic [3:0] idx);
        color_t c;
        case (idx)
            4'd0:    c = 24'hFF2000;
            4'd1:    c = 24'hFF2747;
            4'd2:    c = 24'h00FF60;
            4'd3:    c = 24'hFF0000;
            4'd4:    c = 24'h0020FF;
            4'd5:    c = 24'hF0F0FF;
            4'd6:    c = 24'hFFFF00;
            4'd7:    c = 24'h4000FF;
            4'd8:    c = 24'hFF0060;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    // Rainbow wheel colors.
    function automatic color_t rainbow_color(input step_t step);
        color_t c;
        case (step)
            6'd0:    c = 24'hFF0000;
            6'd1:    c = 24'hFF0000;
            6'd2:    c = 24'hFF0000;
            6'd3:    c = 24'hFF0F00;
            6'd4:    c = 24'hFF1F00;
            6'd5:    c = 24'hFF3F00;
            6'd6:    c = 24'hFF7F00;
            6'd7:    c = 24'hFFFF00;
            6'd8:    c = 24'hFFFF00;
            6'd9:    c = 24'hFFFF00;
            6'd10:   c = 24'h7FFF00;
            6'd11:   c = 24'h3FFF00;
            6'd12:   c = 24'h1FFF00;
            6'd13:   c = 24'h0FFF00;
            6'd14:   c = 24'h00FF00;
            6'd15:   c = 24'h00FF00;
            6'd16:   c = 24'h00FF00;
            6'd17:   c = 24'h00FF0F;
            6'd18:   c = 24'h00FF1F;
            6'd19:   c = 24'h00FF3F;
            6'd20:   c = 24'h00FF7F;
            6'd21:   c = 24'h00FFFF;
            6'd22:   c = 24'h00FFFF;
            6'd23:   c = 24'h00FFFF;
            6'd24:   c = 24'h007FFF;
            6'd25:   c = 24'h003FFF;
            6'd26:   c = 24'h001FFF;
            6'd27:   c = 24'h000FFF;
            6'd28:   c = 24'h0000FF;
            6'd29:   c = 24'h0000FF;
            6'd30:   c = 24'h0000FF;
            6'd31:   c = 24'h0F00FF;
            6'd32:   c = 24'h1F00FF;
            6'd33:   c = 24'h3F00FF;
            6'd34:   c = 24'h7F00FF;
            6'd35:   c = 24'hFF00FF;
            6'd36:   c = 24'hFF00FF;
            6'd37:   c = 24'hFF00FF;
            6'd38:   c = 24'hFF007F;
            6'd39:   c = 24'hFF003F;
            6'd40:   c = 24'hFF001F;
            6'd41:   c = 24'hFF000F;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/lbct_color.sv @@
module lbct_color
    import lbct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [SEL_W-1:0] sel,
    output color_t           color
);

    logic [SEL_W-1:0] cur_select_reg;
    step_t            step_reg;
    step_t            step_base;
    step_t            step_next;
    logic             sel_change;

    // A new selector restarts the rainbow; the rainbow selector steps it first.
    always_comb
    begin
        sel_change = (sel != cur_select_reg);
        step_base  = sel_change ? '0 : step_reg;
        step_next  = step_base;
        if (sel == SEL_RAINBOW)
        begin
            step_next = (step_base == STEP_W'(RAINBOW_STEPS - 1)) ? '0 : step_base + 1'b1;
        end
    end

    // Negative selectors have the top bit set and fall into the black case.
    always_comb
    begin
        if (sel < PALETTE_SIZE)
        begin
            color = palette_color(sel[3:0]);
        end
        else if (sel == SEL_RAINBOW)
        begin
            color = rainbow_color(step_next);
        end
        else
        begin
            color = '0;
        end
    end

    // Selector and rainbow state move only when an item goes through.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_select_reg <= '0;
            step_reg       <= '0;
        end
        else if (advance)
        begin
            cur_select_reg <= sel;
            step_reg       <= step_next;
        end
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < STEP_W'(RAINBOW_STEPS))
        else $error("rainbow step out of range");

    a_sel_track: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> cur_select_reg == $past(sel))
        else $error("stored selector did not follow the item");

    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(step_reg) && $stable(cur_select_reg))
        else $error("selector state changed without an item");

endmodule

@@ hw/rtl/lbct_scale.sv @@
module lbct_scale
    import lbct_pkg::*;
(
    input  color_t  color,
    input  factor_t factor,
    output color_t  scaled
);

    localparam int PROD_W = CH_W + FACTOR_W;

    logic [PROD_W-1:0] prod [3];

    // Each channel times the reciprocal factor; the quotient sits above the shift.
    for (genvar g = 0; g < 3; g++)
    begin : g_chan
        assign prod[g] = {{FACTOR_W{1'b0}}, color[g*CH_W +: CH_W]}
                       * {{CH_W{1'b0}}, factor};
        assign scaled[g*CH_W +: CH_W] = prod[g][SCALE_SHIFT +: CH_W];
    end

endmodule

@@ hw/rtl/led_bar_color_trail.sv @@
// Color trail for an LED bar. Each tick item carries a color selector
// (0 to 8 palette, 9 rainbow, anything else black) and a brightness that
// saturates at MAX_LEVEL; the picked color is scaled per channel by
// (brightness + 1) / (MAX_LEVEL + 1), pushed into a TRAIL_LEN deep trail,
// and the whole trail comes out as one frame item with slot0 the newest.
// Slots at and beyond TRAIL_LEN read as black. A tick item is held in the
// input register together with its brightness factor, formed on the way in.
// The item moves on into the frame register, which is the trail, once that
// register is free, and the frame item is presented from there. One tick
// item is taken every cycle as long as frame items are taken. The trail and
// the rainbow counter are cleared by reset.
module led_bar_color_trail
    import lbct_pkg::*;
#(
    parameter int MAX_LEVEL = MAX_LEVEL_DEF,
    parameter int TRAIL_LEN = TRAIL_LEN_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   tick_valid,
    output logic   tick_stall,
    input  tick_t  tick,
    output logic   frame_valid,
    input  logic   frame_stall,
    output frame_t frame
);

    localparam int SCALE_DIV = MAX_LEVEL + 1;
    localparam int RECIP     = ((1 << SCALE_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(MAX_LEVEL);
    localparam logic [RECIP_W-1:0] RECIP_K   = RECIP_W'(RECIP);
    localparam int FULL_W = LEVEL_W + 1 + RECIP_W;

    logic               hold_valid_reg;
    logic [SEL_W-1:0]   sel_reg;
    factor_t            factor_reg;
    factor_t            factor_next;
    logic               frame_valid_reg;
    logic               frame_valid_next;
    color_t             trail_reg [TRAIL_LEN];
    logic [LEVEL_W-1:0] level_sat;
    logic [LEVEL_W:0]   level_plus;
    logic [FULL_W-1:0]  factor_full;
    logic               advance;
    logic               take;
    color_t             raw_color;
    color_t             scaled_color;
    color_t             slot_color [SLOTS];

    // Handshake: the held item moves on when the frame register is free.
    assign advance          = hold_valid_reg && (!frame_valid_reg || !frame_stall);
    assign tick_stall       = hold_valid_reg && frame_valid_reg && frame_stall;
    assign take             = tick_valid && !tick_stall;
    assign frame_valid_next = advance || (frame_valid_reg && frame_stall);

    // Saturated brightness times the reciprocal of the scale divisor.
    always_comb
    begin
        level_sat   = (tick.brightness > LEVEL_TOP) ? LEVEL_TOP : tick.brightness;
        level_plus  = {1'b0, level_sat} + 1'b1;
        factor_full = {{RECIP_W{1'b0}}, level_plus} * {{(LEVEL_W + 1){1'b0}}, RECIP_K};
        factor_next = factor_full[FACTOR_W-1:0];
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (take || advance)
        begin
            hold_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sel_reg    <= tick.color_select;
            factor_reg <= factor_next;
        end
    end

    lbct_color u_color
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sel     (sel_reg),
        .color   (raw_color)
    );

    lbct_scale u_scale
    (
        .color  (raw_color),
        .factor (factor_reg),
        .scaled (scaled_color)
    );

    // Trail shift register, which is also the frame register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
            for (int i = 0; i < TRAIL_LEN; i++)
            begin
                trail_reg[i] <= '0;
            end
        end
        else
        begin
            frame_valid_reg <= frame_valid_next;
            if (advance)
            begin
                trail_reg[0] <= scaled_color;
                for (int i = 1; i < TRAIL_LEN; i++)
                begin
                    trail_reg[i] <= trail_reg[i-1];
                end
            end
        end
    end

    // Slots past the trail length stay black.
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_slot
        if (g < TRAIL_LEN)
        begin : g_used
            assign slot_color[g] = trail_reg[g];
        end
        else
        begin : g_unused
            assign slot_color[g] = '0;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame = '{
        slot0_color: slot_color[0],
        slot1_color: slot_color[1],
        slot2_color: slot_color[2],
        slot3_color: slot_color[3],
        slot4_color: slot_color[4],
        slot5_color: slot_color[5],
        slot6_color: slot_color[6],
        slot7_color: slot_color[7]
    };

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> hold_valid_reg && frame_valid_reg)
        else $error("tick stalled without a blocked frame");

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> frame_valid_reg)
        else $error("frame not presented after an item moved on");

    a_trail_shift: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> trail_reg[1] == $past(trail_reg[0]))
        else $error("trail did not shift");

    a_trail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(trail_reg[0]))
        else $error("trail changed without an item");

endmodule
